/* rtl/udfu_pkg.sv */
// ----------------------------------------------------------------------------
// udfu_pkg: shared types and constants for the DFU request state machine
// Request and response words, configuration bundle, state encoding,
// command and status codes.
// ----------------------------------------------------------------------------
package udfu_pkg;

   // Class request codes (bRequest)
   localparam logic [7:0] CMD_DETACH    = 8'd0;
   localparam logic [7:0] CMD_DNLOAD    = 8'd1;
   localparam logic [7:0] CMD_UPLOAD    = 8'd2;
   localparam logic [7:0] CMD_GETSTATUS = 8'd3;
   localparam logic [7:0] CMD_CLRSTATUS = 8'd4;
   localparam logic [7:0] CMD_GETSTATE  = 8'd5;
   localparam logic [7:0] CMD_ABORT     = 8'd6;

   // Status codes
   localparam logic [2:0] SS_OK      = 3'd0;
   localparam logic [2:0] SS_WRITE   = 3'd1;
   localparam logic [2:0] SS_PROG    = 3'd2;
   localparam logic [2:0] SS_ADDRESS = 3'd3;
   localparam logic [2:0] SS_UNKNOWN = 3'd4;
   localparam logic [2:0] SS_STALLED = 3'd5;

   // DFU 1.1 state numbers as reported
   localparam logic [3:0] CODE_APP_DETACH = 4'd1;
   localparam logic [3:0] CODE_IDLE       = 4'd2;
   localparam logic [3:0] CODE_DN_SYNC    = 4'd3;
   localparam logic [3:0] CODE_DN_IDLE    = 4'd5;
   localparam logic [3:0] CODE_MAN_SYNC   = 4'd6;
   localparam logic [3:0] CODE_ERROR      = 4'd10;

   // Fixed reply lengths
   localparam logic [12:0] LEN_GETSTATUS = 13'd6;
   localparam logic [12:0] LEN_GETSTATE  = 13'd1;

   // Register map (word index = paddr[4:2])
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] REG_DETACH_LIMIT  = 3'd0;
   localparam logic [2:0] REG_BLOCK_SIZE    = 3'd1;
   localparam logic [2:0] REG_PROTECT_LIMIT = 3'd2;
   localparam logic [2:0] REG_FLASH_BYTES   = 3'd3;
   localparam logic [2:0] REG_POLL_INTERVAL = 3'd4;

   // Register reset values
   localparam logic [15:0] RST_DETACH_LIMIT  = 16'd1000;
   localparam logic [12:0] RST_BLOCK_SIZE    = 13'd256;
   localparam logic [27:0] RST_PROTECT_LIMIT = 28'h0004000;
   localparam logic [28:0] RST_FLASH_BYTES   = 29'd524288;
   localparam logic [23:0] RST_POLL_INTERVAL = 24'd20;

   // Reachable DFU states, one-hot
   typedef enum logic [5:0] {
      ST_APP_DETACH = 6'b000001,
      ST_IDLE       = 6'b000010,
      ST_DN_SYNC    = 6'b000100,
      ST_DN_IDLE    = 6'b001000,
      ST_MAN_SYNC   = 6'b010000,
      ST_ERROR      = 6'b100000
   } dfu_state_type;

   typedef struct packed {
      logic [7:0]  cmd;
      logic [15:0] req_value;
      logic [15:0] req_length;
      logic        prog_ok;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [12:0] reply_length;
      logic [2:0]  status_now;
      logic [3:0]  state_now;
      logic [23:0] poll_timeout;
      logic        write_strobe;
      logic        read_strobe;
      logic [27:0] block_address;
      logic        dfu_active;
      logic        untouched;
   } rsp_type;

   typedef struct packed {
      logic [15:0] detach_limit;
      logic [12:0] block_size;
      logic [27:0] protect_limit;
      logic [28:0] flash_bytes;
      logic [23:0] poll_interval;
   } cfg_type;

   function automatic logic [3:0] state_code(input dfu_state_type s);
      logic [3:0] code;
      case (s)
         ST_APP_DETACH: code = CODE_APP_DETACH;
         ST_IDLE:       code = CODE_IDLE;
         ST_DN_SYNC:    code = CODE_DN_SYNC;
         ST_DN_IDLE:    code = CODE_DN_IDLE;
         ST_MAN_SYNC:   code = CODE_MAN_SYNC;
         default:       code = CODE_ERROR;
      endcase
      return code;
   endfunction

endpackage

/* rtl/usb_dfu_request_state_machine.sv */
// ----------------------------------------------------------------------------
// usb_dfu_request_state_machine: DFU 1.1 class request handler
// Accepts one class request per word, tracks DFU state, last status and the
// untouched flag, and returns one response word per request.
// ----------------------------------------------------------------------------
//
//   channel   ports                          direction   words
//   req       req_valid/req_stall/req_data   in          one request
//   rsp       rsp_valid/rsp_stall/rsp_data   out         one response each
//   csr       csr_psel ... csr_pready        in/out      register access
//
// Two register stages: the input stage captures the request and forms the
// block address (wValue times block size, one 16x13 multiply); the decode
// stage resolves the request against the current state and loads the
// response register. Throughput is one word per clock unless the response stalls.
// Synchronous active-high reset returns to dfuIDLE, status OK, untouched set,
// empty stages and default configuration registers. A response stall holds
// both stages and backs up into req_stall only when the input stage is occupied.
// ----------------------------------------------------------------------------
module usb_dfu_request_state_machine (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  udfu_pkg::req_type                 req_data,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output udfu_pkg::rsp_type                 rsp_data,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [udfu_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   udfu_pkg::cfg_type        cfg;

   // input stage
   logic                     s1_valid_ff, s1_valid_in;
   udfu_pkg::req_type        s1_req_ff;
   logic [28:0]              s1_addr_ff;

   // response stage
   logic                     rsp_valid_ff, rsp_valid_in;
   udfu_pkg::rsp_type        rsp_ff, rsp_in;

   // protocol state
   udfu_pkg::dfu_state_type  dfu_state_ff, dfu_state_in;
   logic [2:0]               status_ff, status_in;
   logic                     virgin_ff, virgin_in;

   udfu_pkg::dfu_state_type  step_state;
   logic [2:0]               step_status;
   logic                     step_virgin;

   logic                     out_free;
   logic                     s1_fire;
   logic                     req_fire;

   assign csr_pready = 1'b1;

   udfu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // Handshake: the response register frees up when empty or being taken;
   // the input stage then drains into it, and a new word may enter.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   // Decode against the current state
   udfu_step u_step (
      .req        (s1_req_ff),
      .addr       (s1_addr_ff),
      .cfg        (cfg),
      .state      (dfu_state_ff),
      .status     (status_ff),
      .virgin     (virgin_ff),
      .state_nxt  (step_state),
      .status_nxt (step_status),
      .virgin_nxt (step_virgin),
      .rsp        (rsp_in)
   );

   // Commit the state only when the decoded word moves to the response register
   assign dfu_state_in = s1_fire ? step_state  : dfu_state_ff;
   assign status_in    = s1_fire ? step_status : status_ff;
   assign virgin_in    = s1_fire ? step_virgin : virgin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dfu_state_ff <= udfu_pkg::ST_IDLE;
         status_ff    <= udfu_pkg::SS_OK;
         virgin_ff    <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         dfu_state_ff <= dfu_state_in;
         status_ff    <= status_in;
         virgin_ff    <= virgin_in;
      end
   end

   // Payload: request, block address on accept; response on drain; else hold
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff  <= req_data;
         s1_addr_ff <= 29'(req_data.req_value * cfg.block_size);
      end
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_strobe_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.write_strobe && rsp_ff.read_strobe))
      else $error("write and read strobe both set");

   a_upload_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.read_strobe) |->
         (rsp_ff.accepted && rsp_ff.state_now == udfu_pkg::CODE_IDLE))
      else $error("upload did not return to idle");

   a_stall_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.accepted) |->
         (rsp_ff.reply_length == 13'd0 && rsp_ff.poll_timeout == 24'd0))
      else $error("stalled request carries reply data");

   a_virgin_sticky: assert property (@(posedge clock) disable iff (reset)
      !virgin_ff |=> !virgin_ff)
      else $error("untouched flag set again");

endmodule

/* rtl/udfu_csr.sv */
// ----------------------------------------------------------------------------
// udfu_csr: configuration registers
// APB-style register file holding limits, block size, flash size and poll
// interval; always ready, reads return the stored value.
// ----------------------------------------------------------------------------
module udfu_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [udfu_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output udfu_pkg::cfg_type                  cfg
);

   udfu_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            udfu_pkg::REG_DETACH_LIMIT:  cfg_in.detach_limit  = pwdata[15:0];
            udfu_pkg::REG_BLOCK_SIZE:    cfg_in.block_size    = pwdata[12:0];
            udfu_pkg::REG_PROTECT_LIMIT: cfg_in.protect_limit = pwdata[27:0];
            udfu_pkg::REG_FLASH_BYTES:   cfg_in.flash_bytes   = pwdata[28:0];
            udfu_pkg::REG_POLL_INTERVAL: cfg_in.poll_interval = pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detach_limit  <= udfu_pkg::RST_DETACH_LIMIT;
         cfg_ff.block_size    <= udfu_pkg::RST_BLOCK_SIZE;
         cfg_ff.protect_limit <= udfu_pkg::RST_PROTECT_LIMIT;
         cfg_ff.flash_bytes   <= udfu_pkg::RST_FLASH_BYTES;
         cfg_ff.poll_interval <= udfu_pkg::RST_POLL_INTERVAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         udfu_pkg::REG_DETACH_LIMIT:  prdata = {16'd0, cfg_ff.detach_limit};
         udfu_pkg::REG_BLOCK_SIZE:    prdata = {19'd0, cfg_ff.block_size};
         udfu_pkg::REG_PROTECT_LIMIT: prdata = {4'd0, cfg_ff.protect_limit};
         udfu_pkg::REG_FLASH_BYTES:   prdata = {3'd0, cfg_ff.flash_bytes};
         udfu_pkg::REG_POLL_INTERVAL: prdata = {8'd0, cfg_ff.poll_interval};
         default:                     prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/udfu_step.sv */
// ----------------------------------------------------------------------------
// udfu_step: request decode and next-state logic
// Decides accept or stall for one registered request, forms the next DFU
// state, status and untouched flag, and builds the response word.
// ----------------------------------------------------------------------------
module udfu_step (
   input  udfu_pkg::req_type        req,
   input  logic [28:0]              addr,
   input  udfu_pkg::cfg_type        cfg,
   input  udfu_pkg::dfu_state_type  state,
   input  logic [2:0]               status,
   input  logic                     virgin,
   output udfu_pkg::dfu_state_type  state_nxt,
   output logic [2:0]               status_nxt,
   output logic                     virgin_nxt,
   output udfu_pkg::rsp_type        rsp
);

   logic        ok, wr, rd, put, err;
   logic [2:0]  err_code;
   logic [12:0] rlen;
   logic [23:0] poll;
   logic        len_zero, val_zero, len_is_block;
   logic        below_protect, in_flash;
   logic [29:0] addr_end;

   assign len_zero      = (req.req_length == 16'd0);
   assign val_zero      = (req.req_value == 16'd0);
   assign len_is_block  = (req.req_length == {3'd0, cfg.block_size});
   assign below_protect = (addr < {1'b0, cfg.protect_limit});
   assign addr_end      = {1'b0, addr} + {14'd0, req.req_length};
   assign in_flash      = !len_zero && (addr < cfg.flash_bytes)
                          && (addr_end <= {1'b0, cfg.flash_bytes});

   always_comb begin
      ok         = 1'b0;
      wr         = 1'b0;
      rd         = 1'b0;
      put        = 1'b0;
      err        = 1'b0;
      err_code   = udfu_pkg::SS_OK;
      rlen       = 13'd0;
      poll       = 24'd0;
      state_nxt  = state;
      status_nxt = status;

      case (req.cmd)
         udfu_pkg::CMD_DETACH: begin
            if (len_zero && (req.req_value <= cfg.detach_limit)) begin
               state_nxt = udfu_pkg::ST_APP_DETACH;
               put       = 1'b1;
               ok        = 1'b1;
            end else begin
               err      = 1'b1;
               err_code = udfu_pkg::SS_UNKNOWN;
            end
         end
         udfu_pkg::CMD_DNLOAD: begin
            if (len_zero) begin
               if (state != udfu_pkg::ST_DN_IDLE) begin
                  err      = 1'b1;
                  err_code = udfu_pkg::SS_STALLED;
               end else begin
                  state_nxt = udfu_pkg::ST_MAN_SYNC;
                  put       = 1'b1;
                  ok        = 1'b1;
               end
            end else if (len_is_block) begin
               if (state != udfu_pkg::ST_IDLE && state != udfu_pkg::ST_DN_IDLE) begin
                  err      = 1'b1;
                  err_code = udfu_pkg::SS_STALLED;
               end else if (below_protect) begin
                  err      = 1'b1;
                  err_code = udfu_pkg::SS_WRITE;
               end else begin
                  // strobe even when programming fails: the write was attempted
                  wr = 1'b1;
                  if (req.prog_ok) begin
                     state_nxt = udfu_pkg::ST_DN_SYNC;
                     put       = 1'b1;
                     ok        = 1'b1;
                  end else begin
                     err      = 1'b1;
                     err_code = udfu_pkg::SS_PROG;
                  end
               end
            end else begin
               err      = 1'b1;
               err_code = udfu_pkg::SS_UNKNOWN;
            end
         end
         udfu_pkg::CMD_UPLOAD: begin
            if (len_is_block) begin
               if (state != udfu_pkg::ST_IDLE) begin
                  err      = 1'b1;
                  err_code = udfu_pkg::SS_STALLED;
               end else if (in_flash) begin
                  rd        = 1'b1;
                  rlen      = cfg.block_size;
                  state_nxt = udfu_pkg::ST_IDLE;
                  put       = 1'b1;
                  ok        = 1'b1;
               end else begin
                  err      = 1'b1;
                  err_code = udfu_pkg::SS_ADDRESS;
               end
            end else begin
               err      = 1'b1;
               err_code = udfu_pkg::SS_UNKNOWN;
            end
         end
         udfu_pkg::CMD_GETSTATUS: begin
            // a malformed status request stalls without touching state
            if (val_zero && (req.req_length == 16'd6)) begin
               if (state == udfu_pkg::ST_DN_SYNC) begin
                  state_nxt = udfu_pkg::ST_DN_IDLE;
                  put       = 1'b1;
               end else if (state == udfu_pkg::ST_MAN_SYNC) begin
                  state_nxt = udfu_pkg::ST_IDLE;
                  put       = 1'b1;
               end
               rlen = udfu_pkg::LEN_GETSTATUS;
               poll = cfg.poll_interval;
               ok   = 1'b1;
            end
         end
         udfu_pkg::CMD_CLRSTATUS: begin
            if (val_zero && len_zero && state == udfu_pkg::ST_ERROR) begin
               status_nxt = udfu_pkg::SS_OK;
               state_nxt  = udfu_pkg::ST_IDLE;
               put        = 1'b1;
               ok         = 1'b1;
            end else begin
               err      = 1'b1;
               err_code = udfu_pkg::SS_UNKNOWN;
            end
         end
         udfu_pkg::CMD_GETSTATE: begin
            if (val_zero && (req.req_length == 16'd1)) begin
               rlen = udfu_pkg::LEN_GETSTATE;
               ok   = 1'b1;
            end else begin
               err      = 1'b1;
               err_code = udfu_pkg::SS_UNKNOWN;
            end
         end
         udfu_pkg::CMD_ABORT: begin
            if (val_zero && len_zero && state != udfu_pkg::ST_ERROR) begin
               state_nxt = udfu_pkg::ST_IDLE;
               put       = 1'b1;
               ok        = 1'b1;
            end else begin
               err      = 1'b1;
               err_code = udfu_pkg::SS_UNKNOWN;
            end
         end
         default: ;
      endcase

      // record the failure; application states keep their state
      if (err) begin
         status_nxt = err_code;
         if (state != udfu_pkg::ST_APP_DETACH) begin
            state_nxt = udfu_pkg::ST_ERROR;
            put       = 1'b1;
         end
      end
   end

   assign virgin_nxt = virgin & ~put;

   always_comb begin
      rsp.accepted      = ok;
      rsp.reply_length  = ok ? rlen : 13'd0;
      rsp.status_now    = status_nxt;
      rsp.state_now     = udfu_pkg::state_code(state_nxt);
      rsp.poll_timeout  = ok ? poll : 24'd0;
      rsp.write_strobe  = wr;
      rsp.read_strobe   = rd;
      rsp.block_address = (wr | rd) ? addr[27:0] : 28'd0;
      rsp.dfu_active    = (state_nxt != udfu_pkg::ST_APP_DETACH);
      rsp.untouched     = virgin_nxt;
   end

endmodule
